// File: design/scfb_pkg.sv
// Shared types, constants and the CRC byte update for the SLIP frame builder.
`timescale 1ns / 1ps
`default_nettype none
package scfb_pkg;

	localparam int PayloadBytes = 8;
	localparam int LaneIdxW     = $clog2(PayloadBytes);

	// Input transaction: two wheel speeds
	typedef struct packed {
		logic signed [31:0] left_speed;
		logic signed [31:0] right_speed;
	} speed_t;

	// Output transaction: one link byte
	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_last;
	} frame_out_t;

	// Framing codes held in the configuration registers
	typedef struct packed {
		logic [7:0] end_code;
		logic [7:0] escape_code;
		logic [7:0] escaped_end_code;
		logic [7:0] escaped_escape_code;
		logic [7:0] command_code;
	} codes_t;

	// What one lane found for its payload byte
	typedef struct packed {
		logic       dbl;
		logic [7:0] b0;
		logic [7:0] b1;
	} lane_t;

	// Escaped payload of one frame plus its length byte
	typedef struct packed {
		lane_t [PayloadBytes-1:0] lanes;
		logic  [7:0]              len;
	} frame_t;

	typedef enum logic [7:0] {
		REG_END_CODE            = 8'd0,
		REG_ESCAPE_CODE         = 8'd1,
		REG_ESCAPED_END_CODE    = 8'd2,
		REG_ESCAPED_ESCAPE_CODE = 8'd3,
		REG_COMMAND_CODE        = 8'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SOF,
		PH_LEN,
		PH_CMD,
		PH_PAY,
		PH_CRC_LO,
		PH_CRC_HI,
		PH_EOF
	} phase_t;

	localparam logic [7:0] ResetEndCode       = 8'hC0;
	localparam logic [7:0] ResetEscapeCode    = 8'hDB;
	localparam logic [7:0] ResetEscEndCode    = 8'hDC;
	localparam logic [7:0] ResetEscEscapeCode = 8'hDD;
	localparam logic [7:0] ResetCommandCode   = 8'h00;

	// Reflected CCITT update, one byte
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [7:0]  d;
		logic [15:0] w;
		d = b ^ crc[7:0];
		d = d ^ {d[3:0], 4'b0000};
		w = {d, crc[15:8]};
		w = w ^ {12'b0, d[7:4]};
		w = w ^ {5'b0, d, 3'b000};
		return w;
	endfunction

endpackage
`default_nettype wire

// File: design/scfb_lane.sv
// One escape lane: classifies a payload byte and gives its escaped form.
`timescale 1ns / 1ps
`default_nettype none
module scfb_lane
	import scfb_pkg::*;
(
	input  wire logic [7:0] pay_byte,
	input  wire codes_t     codes,
	output lane_t           lane
);

	// Delimiter test wins over the escape test
	always_comb begin
		lane = '0;
		if (pay_byte == codes.end_code) begin
			lane.dbl = 1'b1;
			lane.b0  = codes.escape_code;
			lane.b1  = codes.escaped_end_code;
		end else if (pay_byte == codes.escape_code) begin
			lane.dbl = 1'b1;
			lane.b0  = codes.escape_code;
			lane.b1  = codes.escaped_escape_code;
		end else begin
			lane.b0  = pay_byte;
		end
	end

endmodule
`default_nettype wire

// File: design/scfb_serializer.sv
// Frame merger: walks the lane results, emits link bytes and runs the CRC.
`timescale 1ns / 1ps
`default_nettype none
module scfb_serializer
	import scfb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire codes_t     codes,
	input  wire frame_t     frm,
	input  wire logic       frm_valid,
	output logic            take,
	output logic            out_valid,
	input  wire logic       out_stall,
	output frame_out_t      out_data
);

	localparam logic [LaneIdxW-1:0] LastLane = LaneIdxW'(PayloadBytes - 1);

	phase_t                   phase_q, phase_d;
	logic [LaneIdxW-1:0]      idx_q, idx_d;
	logic                     sub_q, sub_d;
	logic [15:0]              crc_q, crc_d;
	lane_t [PayloadBytes-1:0] lanes_q;
	logic [7:0]               len_q;
	logic                     out_valid_q;
	frame_out_t               out_data_q;
	logic                     adv;
	logic                     emit;
	frame_out_t               emit_data;
	lane_t                    cur;

	assign adv       = !out_valid_q || !out_stall;
	assign cur       = lanes_q[idx_q];
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Next phase, next byte and CRC update
	always_comb begin
		phase_d   = phase_q;
		idx_d     = idx_q;
		sub_d     = sub_q;
		crc_d     = crc_q;
		take      = 1'b0;
		emit      = 1'b0;
		emit_data = '0;
		unique case (phase_q)
			PH_IDLE: begin
				if (frm_valid) begin
					take    = 1'b1;
					phase_d = PH_SOF;
				end
			end
			PH_SOF: begin
				if (adv) begin
					emit                 = 1'b1;
					emit_data.frame_byte = codes.end_code;
					phase_d              = PH_LEN;
				end
			end
			PH_LEN: begin
				if (adv) begin
					emit                 = 1'b1;
					emit_data.frame_byte = len_q;
					phase_d              = PH_CMD;
				end
			end
			PH_CMD: begin
				if (adv) begin
					emit                 = 1'b1;
					emit_data.frame_byte = codes.command_code;
					idx_d                = '0;
					sub_d                = 1'b0;
					crc_d                = '0;
					phase_d              = PH_PAY;
				end
			end
			PH_PAY: begin
				if (adv) begin
					emit                 = 1'b1;
					emit_data.frame_byte = sub_q ? cur.b1 : cur.b0;
					crc_d                = crc_step(crc_q, emit_data.frame_byte);
					if (cur.dbl && !sub_q) begin
						sub_d = 1'b1;
					end else begin
						sub_d = 1'b0;
						idx_d = idx_q + 1'b1;
						if (idx_q == LastLane) begin
							phase_d = PH_CRC_LO;
						end
					end
				end
			end
			PH_CRC_LO: begin
				if (adv) begin
					emit                 = 1'b1;
					emit_data.frame_byte = crc_q[7:0];
					phase_d              = PH_CRC_HI;
				end
			end
			PH_CRC_HI: begin
				if (adv) begin
					emit                 = 1'b1;
					emit_data.frame_byte = crc_q[15:8];
					phase_d              = PH_EOF;
				end
			end
			PH_EOF: begin
				if (adv) begin
					emit                 = 1'b1;
					emit_data.frame_byte = codes.end_code;
					emit_data.frame_last = 1'b1;
					if (frm_valid) begin
						take    = 1'b1;
						phase_d = PH_SOF;
					end else begin
						phase_d = PH_IDLE;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// Phase register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (adv) begin
				out_valid_q <= emit;
			end
		end
	end

	// Walk pointers, CRC, loaded frame and output byte
	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		sub_q <= sub_d;
		crc_q <= crc_d;
		if (take) begin
			lanes_q <= frm.lanes;
			len_q   <= frm.len;
		end
		if (adv && emit) begin
			out_data_q <= emit_data;
		end
	end

endmodule
`default_nettype wire

// File: design/slip_crc_frame_builder_top.sv
// Top level of the SLIP frame builder: config registers, escape lanes, frame buffer.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  speed   | in        | speed_valid / stall  | speed_t: left, right speed
//  frame   | out       | frame_valid / stall  | frame_out_t: byte, last flag
//  cfg     | in        | cfg_valid / ready    | cfg_index, cfg_data
//
// A speed transaction yields 14 to 22 frame bytes, one per cycle while the
// sink does not stall; the byte serializer sets that rate. Eight escape lanes
// process all payload bytes in the cycle of acceptance, and one frame waits
// in a buffer while the previous one is sent. Reset loads the SLIP default
// codes and empties both stages. Sink stall freezes the output byte and the walk.
`timescale 1ns / 1ps
`default_nettype none
module slip_crc_frame_builder_top
	import scfb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       speed_valid,
	output logic            speed_stall,
	input  wire speed_t     speed,
	output logic            frame_valid,
	input  wire logic       frame_stall,
	output frame_out_t      frame,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	codes_t                   codes_q;
	logic [7:0]               pay_bytes [PayloadBytes];
	lane_t [PayloadBytes-1:0] lanes;
	logic [PayloadBytes-1:0]  dbl_mask;
	frame_t                   frame_d;
	frame_t                   frame_s1;
	logic                     valid_s1;
	logic                     take;
	logic                     accept;

	assign cfg_ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q.end_code            <= ResetEndCode;
			codes_q.escape_code         <= ResetEscapeCode;
			codes_q.escaped_end_code    <= ResetEscEndCode;
			codes_q.escaped_escape_code <= ResetEscEscapeCode;
			codes_q.command_code        <= ResetCommandCode;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_END_CODE:            codes_q.end_code            <= cfg_data;
				REG_ESCAPE_CODE:         codes_q.escape_code         <= cfg_data;
				REG_ESCAPED_END_CODE:    codes_q.escaped_end_code    <= cfg_data;
				REG_ESCAPED_ESCAPE_CODE: codes_q.escaped_escape_code <= cfg_data;
				REG_COMMAND_CODE:        codes_q.command_code        <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Escape lanes, left speed bytes first, little-endian
	for (genvar g = 0; g < PayloadBytes; g++) begin : g_lane
		if (g < PayloadBytes / 2) begin : g_left
			assign pay_bytes[g] = speed.left_speed[8*g +: 8];
		end else begin : g_right
			assign pay_bytes[g] = speed.right_speed[8*(g - PayloadBytes/2) +: 8];
		end
		scfb_lane u_lane (
			.pay_byte (pay_bytes[g]),
			.codes    (codes_q),
			.lane     (lanes[g])
		);
		assign dbl_mask[g] = lanes[g].dbl;
	end

	// Length byte: escaped payload length plus one
	always_comb begin
		frame_d.lanes = lanes;
		frame_d.len   = 8'(PayloadBytes + 1) + 8'($countones(dbl_mask));
	end

	assign accept      = speed_valid && !speed_stall;
	assign speed_stall = valid_s1 && !take;

	// Hold one escaped frame for the serializer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			frame_s1 <= frame_d;
		end
	end

	scfb_serializer u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.codes     (codes_q),
		.frm       (frame_s1),
		.frm_valid (valid_s1),
		.take      (take),
		.out_valid (frame_valid),
		.out_stall (frame_stall),
		.out_data  (frame)
	);

endmodule
`default_nettype wire

// File: design/scfb_check.sv
// Port checker for the SLIP frame builder and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module scfb_check
	import scfb_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       frame_valid,
	input wire logic       frame_stall,
	input wire frame_out_t frame
);

	logic [4:0] cnt_q;
	logic       frame_acc;

	assign frame_acc = frame_valid && !frame_stall;

	// Count bytes taken since the last closing delimiter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (frame_acc) begin
			if (frame.frame_last) begin
				cnt_q <= '0;
			end else if (cnt_q != 5'd31) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && frame_stall |=> frame_valid)
		else $error("frame valid dropped under stall");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && frame_stall |=> $stable(frame))
		else $error("frame payload changed under stall");

	a_last_len: assert property (@(posedge clk) disable iff (!arst_n)
		frame_acc && frame.frame_last |-> cnt_q >= 5'd13 && cnt_q <= 5'd21)
		else $error("frame closed at a wrong length");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		frame_acc && !frame.frame_last |-> cnt_q < 5'd21)
		else $error("frame ran past its longest length");

endmodule

bind slip_crc_frame_builder_top scfb_check u_scfb_check (.*);
`default_nettype wire

// File: bench/slip_crc_frame_builder_top_tb.sv
// Self-checking testbench for the SLIP frame builder with CRC-16 trailer.
`timescale 1ns / 1ps
module slip_crc_frame_builder_top_tb;
	import scfb_pkg::*;

	localparam int          ClkPeriod     = 10;
	localparam int          LimitCycles   = 1000000;
	localparam int          MaxFrameBytes = 22;
	localparam int          MaxShownErr   = 10;
	localparam logic [7:0]  BadIndexLow   = 8'd5;
	localparam logic [7:0]  BadIndexHigh  = 8'hFF;
	localparam logic [15:0] CrcPolyRefl   = 16'h8408;

	typedef struct packed {
		logic [7:0] end_code;
		logic [7:0] escape_code;
		logic [7:0] esc_end;
		logic [7:0] esc_esc;
		logic [7:0] command;
	} link_codes_t;

	typedef struct {
		speed_t spd;
		bit     drain_first;
	} speed_job_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       speed_valid = 1'b0;
	logic       speed_stall;
	speed_t     speed = '0;
	logic       frame_valid;
	logic       frame_stall = 1'b0;
	frame_out_t frame;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_index = 8'd0;
	logic [7:0] cfg_data = 8'd0;

	link_codes_t codes = '{ResetEndCode, ResetEscapeCode, ResetEscEndCode,
		ResetEscEscapeCode, ResetCommandCode};
	speed_job_t  speed_jobs[$];
	frame_out_t  expected_bytes[$];
	int          mismatch_count = 0;
	int          cycle_count = 0;
	int          speed_gap_left = 0;
	int          sink_stall_left = 0;
	bit          no_idle = 1'b0;
	logic        speed_accepted = 1'b0;

	slip_crc_frame_builder_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.speed_valid(speed_valid),
		.speed_stall(speed_stall),
		.speed      (speed),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.frame      (frame),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		forever #(ClkPeriod / 2) clk = ~clk;
	end

	// Reflected CCITT, bit at a time
	function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CrcPolyRefl) : (c >> 1);
		end
		return c;
	endfunction

	function automatic void push_link_byte(input logic [7:0] b, input logic last);
		frame_out_t fb;
		fb.frame_byte = b;
		fb.frame_last = last;
		expected_bytes.push_back(fb);
	endfunction

	// Build the whole expected frame for one speed transaction
	function automatic void queue_expected_frame(input speed_t s);
		logic [7:0]  pay[8];
		logic [7:0]  stuffed[16];
		logic [15:0] crc;
		int          n;
		n = 0;
		crc = 16'h0000;
		for (int i = 0; i < 4; i++) begin
			pay[i]     = s.left_speed[8*i +: 8];
			pay[i + 4] = s.right_speed[8*i +: 8];
		end
		for (int i = 0; i < 8; i++) begin
			if (pay[i] == codes.end_code) begin
				stuffed[n]     = codes.escape_code;
				stuffed[n + 1] = codes.esc_end;
				n += 2;
			end else if (pay[i] == codes.escape_code) begin
				stuffed[n]     = codes.escape_code;
				stuffed[n + 1] = codes.esc_esc;
				n += 2;
			end else begin
				stuffed[n] = pay[i];
				n += 1;
			end
		end
		for (int i = 0; i < n; i++) begin
			crc = crc_ccitt_byte(crc, stuffed[i]);
		end
		push_link_byte(codes.end_code, 1'b0);
		push_link_byte(8'(n + 1), 1'b0);
		push_link_byte(codes.command, 1'b0);
		for (int i = 0; i < n; i++) begin
			push_link_byte(stuffed[i], 1'b0);
		end
		push_link_byte(crc[7:0], 1'b0);
		push_link_byte(crc[15:8], 1'b0);
		push_link_byte(codes.end_code, 1'b1);
	endfunction

	// Bias bytes toward the active codes so escaping happens often
	function automatic logic [31:0] random_speed_word();
		logic [31:0] w;
		int          pick;
		w = $urandom;
		if ($urandom_range(0, 1) == 0) begin
			for (int k = 0; k < 4; k++) begin
				pick = $urandom_range(0, 11);
				if (pick == 0)      w[8*k +: 8] = codes.end_code;
				else if (pick == 1) w[8*k +: 8] = codes.escape_code;
				else if (pick == 2) w[8*k +: 8] = codes.esc_end;
				else if (pick == 3) w[8*k +: 8] = codes.esc_esc;
				else if (pick == 4) w[8*k +: 8] = 8'h00;
				else if (pick == 5) w[8*k +: 8] = 8'hFF;
			end
		end
		return w;
	endfunction

	function automatic int draw_idle();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60) return 0;
		if (r < 93) return $urandom_range(1, 4);
		return $urandom_range(15, 50);
	endfunction

	function automatic void add_speed(input logic [31:0] l, input logic [31:0] r,
			input bit drain);
		speed_job_t job;
		job.spd.left_speed  = l;
		job.spd.right_speed = r;
		job.drain_first     = drain;
		speed_jobs.push_back(job);
	endfunction

	// Drive speed transactions from the pending queue
	always @(negedge clk) begin
		if (!arst_n || (speed_valid && !speed_accepted)) begin
			// hold the stalled transaction
		end else if (speed_gap_left > 0) begin
			speed_valid <= 1'b0;
			speed_gap_left <= speed_gap_left - 1;
		end else if (speed_jobs.size() > 0 &&
				!(speed_jobs[0].drain_first && expected_bytes.size() != 0)) begin
			speed <= speed_jobs[0].spd;
			speed_valid <= 1'b1;
			speed_gap_left <= draw_idle();
			void'(speed_jobs.pop_front());
		end else begin
			speed_valid <= 1'b0;
		end
	end

	// Stall the frame output at random
	always @(negedge clk) begin
		if (sink_stall_left > 0) begin
			frame_stall <= 1'b1;
			sink_stall_left <= sink_stall_left - 1;
		end else begin
			sink_stall_left <= draw_idle();
			frame_stall <= 1'b0;
		end
	end

	// Predict on accepted speed transactions, check accepted frame bytes
	always @(posedge clk) begin
		frame_out_t want;
		speed_accepted <= speed_valid && !speed_stall;
		if (arst_n && frame_valid && !frame_stall) begin
			if (expected_bytes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MaxShownErr)
					$display("frame byte %h last %b arrived with nothing expected",
						frame.frame_byte, frame.frame_last);
			end else begin
				want = expected_bytes.pop_front();
				if (frame.frame_byte !== want.frame_byte ||
						frame.frame_last !== want.frame_last) begin
					mismatch_count++;
					if (mismatch_count <= MaxShownErr)
						$display("mismatch: byte exp %h got %h, last exp %b got %b",
							want.frame_byte, frame.frame_byte,
							want.frame_last, frame.frame_last);
				end
			end
		end
		if (arst_n && speed_valid && !speed_stall)
			queue_expected_frame(speed);
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LimitCycles) begin
			$display("** slip_crc_frame_builder_top: FAILED **");
			$finish;
		end
	end

	task automatic write_code(input logic [7:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_END_CODE:            codes.end_code = val;
			REG_ESCAPE_CODE:         codes.escape_code = val;
			REG_ESCAPED_END_CODE:    codes.esc_end = val;
			REG_ESCAPED_ESCAPE_CODE: codes.esc_esc = val;
			REG_COMMAND_CODE:        codes.command = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all_codes(input link_codes_t c);
		write_code(REG_END_CODE, c.end_code);
		write_code(REG_ESCAPE_CODE, c.escape_code);
		write_code(REG_ESCAPED_END_CODE, c.esc_end);
		write_code(REG_ESCAPED_ESCAPE_CODE, c.esc_esc);
		write_code(REG_COMMAND_CODE, c.command);
	endtask

	// Wait until every frame has been sent, then let the pipeline settle
	task automatic wait_drained();
		do @(posedge clk);
		while (speed_jobs.size() != 0 || speed_valid || expected_bytes.size() != 0);
		repeat (2 * MaxFrameBytes) @(posedge clk);
	endtask

	task automatic add_random(input int count);
		for (int i = 0; i < count; i++) begin
			add_speed(random_speed_word(), random_speed_word(), $urandom_range(0, 24) == 0);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset codes: field extremes, all-delimiter and escape-heavy payloads
		add_speed(32'h0000_0000, 32'h0000_0000, 1'b0);
		add_speed(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		add_speed(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		add_speed(32'hC0C0_C0C0, 32'hC0C0_C0C0, 1'b0);
		add_speed(32'hDBDB_DBDB, 32'hDCDD_DCDD, 1'b0);
		add_speed(32'h01C0_DB02, 32'h00DD_DC00, 1'b0);
		add_speed(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
		add_random(15);
		wait_drained();

		// Extreme codes: zero is the delimiter, all-ones the escape
		write_all_codes('{8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF});
		add_speed(32'h0000_0000, 32'h0000_0000, 1'b0);
		add_speed(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		add_speed(32'h00FF_00FF, 32'hFF00_FF00, 1'b0);
		add_random(20);
		wait_drained();

		// Equal delimiter and escape: delimiter test wins; no idling
		no_idle = 1'b1;
		write_all_codes('{8'h55, 8'h55, 8'h56, 8'h57, 8'h55});
		add_speed(32'h5555_5555, 32'h1234_5555, 1'b0);
		add_speed(32'h5657_5655, 32'h0000_0055, 1'b0);
		add_random(20);
		wait_drained();
		no_idle = 1'b0;

		// Length and command bytes that collide with the codes
		write_all_codes('{8'h09, 8'h0A, 8'h10, 8'h11, 8'h09});
		add_speed(32'h0102_0304, 32'h0506_0708, 1'b0);
		add_speed(32'h0102_0309, 32'h0506_0708, 1'b0);
		add_random(20);
		wait_drained();

		// Ignored indexes, then substitutes equal to the codes themselves
		write_code(BadIndexLow, 8'h11);
		write_code(BadIndexHigh, 8'h22);
		write_all_codes('{8'h7E, 8'h7D, 8'h7E, 8'h7D, 8'h80});
		add_speed(32'h7E7D_7E7D, 32'h7D7E_0000, 1'b0);
		add_random(20);
		wait_drained();

		if (mismatch_count == 0 && expected_bytes.size() == 0) begin
			$display("** slip_crc_frame_builder_top: PASSED **");
		end else begin
			$display("** slip_crc_frame_builder_top: FAILED **");
		end
		$finish;
	end

endmodule

// File: slip_crc_frame_builder_top.f
design/scfb_pkg.sv
design/scfb_lane.sv
design/scfb_serializer.sv
design/slip_crc_frame_builder_top.sv
design/scfb_check.sv
bench/slip_crc_frame_builder_top_tb.sv
